// ===== design/blgl_pkg.sv =====
// Shared types and constants for the bitmap glyph layout block.
package blgl_pkg;

   localparam int CODE_W  = 8;
   localparam int ATLAS_W = 12;
   localparam int ADV_W   = 8;
   localparam int POS_W   = 16;
   localparam int CFG_W   = 8;

   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [1:0] KIND_QUAD    = 2'd0;
   localparam logic [1:0] KIND_MISSING = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam logic [1:0] CMD_GLYPH   = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_DONE    = 2'd2;
   localparam logic [1:0] CMD_NEWLINE = 2'd3;

   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic             CSR_GLYPH_WIDTH  = 1'b0;
   localparam logic             CSR_GLYPH_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] HEIGHT_RESET     = 8'd8;

   localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [CODE_W-1:0]  char_code;
      logic [ATLAS_W-1:0] atlas_x;
      logic [ATLAS_W-1:0] atlas_y;
      logic [ADV_W-1:0]   glyph_advance;
      logic               glyph_present;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [POS_W-1:0]   screen_x;
      logic [POS_W-1:0]   screen_y;
      logic [ATLAS_W-1:0] tex_x;
      logic [ATLAS_W-1:0] tex_y;
      logic [POS_W-1:0]   text_width;
      logic [POS_W-1:0]   text_height;
   } rsp_type;

   // Classified command handed from the front to the back
   typedef struct packed {
      logic [1:0]         cmd;
      logic               in_range;
      logic [CODE_W-1:0]  code;
      logic [ATLAS_W-1:0] atlas_x;
      logic [ATLAS_W-1:0] atlas_y;
      logic [ADV_W-1:0]   advance;
      logic               present;
   } cmd_type;

   typedef struct packed {
      logic [ATLAS_W-1:0] atlas_x;
      logic [ATLAS_W-1:0] atlas_y;
      logic [ADV_W-1:0]   advance;
   } glyph_type;

endpackage

// ===== design/blgl_front.sv =====
// Front end: classifies incoming words into commands for the back end.
module blgl_front import blgl_pkg::*; #(
   parameter int GLYPH_ENTRIES = 256
) (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_data
);

   localparam logic [CODE_W:0] ENTRY_LIMIT = (CODE_W+1)'(GLYPH_ENTRIES);

   always_comb begin
      push_data.in_range = ({1'b0, req_data.char_code} < ENTRY_LIMIT);
      push_data.code     = req_data.char_code;
      push_data.atlas_x  = req_data.atlas_x;
      push_data.atlas_y  = req_data.atlas_y;
      push_data.advance  = req_data.glyph_advance;
      push_data.present  = req_data.glyph_present;
      push_data.cmd      = CMD_GLYPH;
      push_valid         = 1'b0;
      unique case (req_data.opcode)
         OP_CHAR: begin
            push_valid    = req_valid;
            push_data.cmd = (req_data.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_GLYPH;
         end
         OP_WRITE: begin
            push_valid    = req_valid;
            push_data.cmd = CMD_WRITE;
         end
         OP_END: begin
            push_valid    = req_valid;
            push_data.cmd = CMD_DONE;
         end
         default: begin
            // drop the unused opcode
            push_valid = 1'b0;
         end
      endcase
      // an unused opcode is taken once the queue has room and dropped without a push
      req_ready = push_ready;
   end

endmodule

// ===== design/blgl_queue.sv =====
// Two-entry command queue between the front and the back end.
module blgl_queue import blgl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/blgl_back.sv =====
// Back end: glyph table, pen state and the result register.
module blgl_back import blgl_pkg::*; #(
   parameter int GLYPH_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] glyph_height,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  cmd_type          cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int IDX_W = $clog2(GLYPH_ENTRIES);

   glyph_type         table_mem [GLYPH_ENTRIES];
   logic              present_ff [GLYPH_ENTRIES];
   logic [IDX_W-1:0]  idx;

   logic              s2_valid_ff;
   cmd_type           s2_cmd_ff;
   glyph_type         s2_glyph_ff;
   logic              s2_present_ff;
   logic              s2_adv;

   logic [POS_W-1:0]  pen_x_ff, pen_x_in;
   logic [POS_W-1:0]  pen_y_ff, pen_y_in;
   logic [POS_W-1:0]  widest_ff, widest_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [POS_W:0]    x_sum, y_sum;
   logic [POS_W-1:0]  x_sat, y_sat, line_max;
   logic              emit;

   assign idx      = cmd_data.code[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_adv   = !s2_valid_ff || out_free;
   assign cmd_pop  = cmd_valid && s2_adv;

   // table write and registered table read share the pop edge
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         if (cmd_data.cmd == CMD_WRITE && cmd_data.in_range) begin
            table_mem[idx] <= '{atlas_x: cmd_data.atlas_x, atlas_y: cmd_data.atlas_y,
                                advance: cmd_data.advance};
         end
         s2_glyph_ff   <= table_mem[idx];
         s2_present_ff <= present_ff[idx];
         s2_cmd_ff     <= cmd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GLYPH_ENTRIES; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else if (cmd_pop && cmd_data.cmd == CMD_WRITE && cmd_data.in_range) begin
         present_ff[idx] <= cmd_data.present;
      end
   end

   always_comb begin
      x_sum    = {1'b0, pen_x_ff} + {{(POS_W+1-ADV_W){1'b0}}, s2_glyph_ff.advance};
      y_sum    = {1'b0, pen_y_ff} + {{(POS_W+1-CFG_W){1'b0}}, glyph_height};
      x_sat    = x_sum[POS_W] ? POS_MAX : x_sum[POS_W-1:0];
      y_sat    = y_sum[POS_W] ? POS_MAX : y_sum[POS_W-1:0];
      line_max = (pen_x_ff > widest_ff) ? pen_x_ff : widest_ff;

      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      widest_in   = widest_ff;
      emit        = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.screen_x = pen_x_ff;
      rsp_data_in.screen_y = pen_y_ff;

      unique case (s2_cmd_ff.cmd)
         CMD_GLYPH: begin
            emit = 1'b1;
            if (s2_cmd_ff.in_range && s2_present_ff) begin
               rsp_data_in.kind  = KIND_QUAD;
               rsp_data_in.tex_x = s2_glyph_ff.atlas_x;
               rsp_data_in.tex_y = s2_glyph_ff.atlas_y;
               pen_x_in          = x_sat;
            end else begin
               rsp_data_in.kind = KIND_MISSING;
            end
         end
         CMD_NEWLINE: begin
            widest_in = line_max;
            pen_x_in  = '0;
            pen_y_in  = y_sat;
         end
         CMD_DONE: begin
            emit                    = 1'b1;
            rsp_data_in.kind        = KIND_DONE;
            rsp_data_in.screen_x    = '0;
            rsp_data_in.screen_y    = '0;
            rsp_data_in.text_width  = line_max;
            rsp_data_in.text_height = y_sat;
            pen_x_in                = '0;
            pen_y_in                = '0;
            widest_in               = '0;
         end
         CMD_WRITE: begin
            emit = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      // hold the pen unless stage two retires a command this cycle
      if (!(s2_valid_ff && out_free)) begin
         pen_x_in  = pen_x_ff;
         pen_y_in  = pen_y_ff;
         widest_in = widest_ff;
      end

      if (s2_valid_ff && out_free && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         widest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_adv) begin
            s2_valid_ff <= cmd_valid;
         end
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         widest_ff    <= widest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/bitmap_glyph_layout.sv =====
// Top level of the bitmap glyph layout block.
//
// Usage:
//   req_* carries one word per character, glyph table write or end of string,
//   under valid/ready. Table writes and newlines give no result; a character
//   gives a glyph quad (pen position and atlas corner) or a missing glyph
//   flag; an end of string gives the text width and height and resets the pen.
//   rsp_* returns results in order under valid/ready.
//   csr_* writes a configuration register: index 1 sets the line
//   step (glyph height). Index 0, the cell width, is accepted but has no
//   effect because only top-left corners are emitted.
// Timing:
//   One word per cycle sustained while rsp_ready stays high. A result passes
//   through the command queue, the table read stage and the result register.
//   Each word reads the glyph table once; a table write also writes it.
// Reset:
//   Synchronous, active high. Clears the pen, the widest line, the queue and
//   the presence bit of every table entry at once; the line step returns to 8.
// Stalls:
//   When rsp_ready is low the result register holds; the back end stalls and
//   the two-entry queue keeps taking words until it fills, then req_ready drops.
module bitmap_glyph_layout import blgl_pkg::*; #(
   parameter int GLYPH_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] glyph_height_ff;

   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   // latch the line step; the cell width register needs no storage
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_height_ff <= HEIGHT_RESET;
      end else if (csr_we && csr_index == CSR_GLYPH_HEIGHT) begin
         glyph_height_ff <= csr_wdata;
      end
   end

   // classify each word: character, newline, table write or end of string
   blgl_front #(
      .GLYPH_ENTRIES (GLYPH_ENTRIES)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple the front from back-end stalls
   blgl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop        (cmd_pop),
      .pop_data   (cmd_data)
   );

   // table lookup, pen advance and result register
   blgl_back #(
      .GLYPH_ENTRIES (GLYPH_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .glyph_height (glyph_height_ff),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd_data     (cmd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
